[rtl/core/v3alu_pkg.sv]
// Shared types and constants of the fixed-point 3D vector unit.
`timescale 1ns / 1ps
`default_nettype none

package v3alu_pkg;

  // Square root steps: one root bit per stage, 64-bit radicand.
  localparam int unsigned SQRT_STEPS = 32;
  // Normalise quotient is at most 2^16, so 17 quotient bits suffice.
  localparam int unsigned DIV_STEPS = 17;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_DOT   = 3'd2,
    OP_CROSS = 3'd3,
    OP_MAG   = 3'd4,
    OP_NORM  = 3'd5,
    OP_SCALE = 3'd6
  } opcode_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] scale_factor;
  } item_t;

  typedef struct packed {
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic signed [31:0] result_z;
    logic               saturated;
  } result_t;

  // Data that rides alongside the square root and divider stages.
  typedef struct packed {
    logic [2:0]         opcode;
    result_t            prelim;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } side_t;

endpackage

`default_nettype wire

[rtl/core/v3alu_front.sv]
// Front stages: operand select, products, combine and saturate, sum of squares.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_front
  import v3alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  item_t       in_item,
  output logic        out_valid,
  output side_t       out_side,
  output logic [63:0] out_sumsq
);

  function automatic logic [32:0] clip32(input logic signed [49:0] v);
    logic [32:0] r;
    if (v[49:31] == {19{v[49]}}) begin
      r = {1'b0, v[31:0]};
    end else begin
      r = {1'b1, v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    end
    return r;
  endfunction

  logic signed [31:0] fa [3];
  logic signed [31:0] fb [3];
  logic signed [31:0] ma_next [6];
  logic signed [31:0] mb_next [6];

  // Stage 1 registers
  logic               s1_v;
  logic [2:0]         s1_op;
  logic signed [31:0] s1_a [3];
  logic signed [31:0] s1_b [3];
  logic signed [31:0] s1_ma [6];
  logic signed [31:0] s1_mb [6];

  // Stage 2 registers
  logic               s2_v;
  logic [2:0]         s2_op;
  logic signed [31:0] s2_a [3];
  logic signed [31:0] s2_b [3];
  logic signed [63:0] s2_prod [6];

  // Stage 3 registers
  logic               s3_v;
  logic [2:0]         s3_op;
  logic signed [31:0] s3_a [3];
  logic signed [49:0] s3_w [3];
  logic [63:0]        s3_sumsq;

  logic signed [49:0] t [6];
  logic signed [49:0] ea [3];
  logic signed [49:0] eb [3];
  logic signed [49:0] w_next [3];
  logic [63:0]        sumsq_next;
  logic [32:0]        cl [3];

  // Pick multiplier operands for the opcode
  always_comb begin
    fa[0] = in_item.first_x;
    fa[1] = in_item.first_y;
    fa[2] = in_item.first_z;
    fb[0] = in_item.second_x;
    fb[1] = in_item.second_y;
    fb[2] = in_item.second_z;
    for (int i = 0; i < 6; i++) begin
      ma_next[i] = '0;
      mb_next[i] = '0;
    end
    unique case (in_item.opcode)
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          ma_next[i] = fa[i];
          mb_next[i] = fb[i];
        end
      end
      OP_CROSS: begin
        ma_next[0] = fa[1]; mb_next[0] = fb[2];
        ma_next[1] = fa[2]; mb_next[1] = fb[1];
        ma_next[2] = fa[2]; mb_next[2] = fb[0];
        ma_next[3] = fa[0]; mb_next[3] = fb[2];
        ma_next[4] = fa[0]; mb_next[4] = fb[1];
        ma_next[5] = fa[1]; mb_next[5] = fb[0];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ma_next[i] = fa[i];
          mb_next[i] = in_item.scale_factor;
        end
      end
      OP_MAG, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          ma_next[i] = fa[i];
          mb_next[i] = fa[i];
        end
      end
      default: begin
      end
    endcase
  end

  // Shift products to Q16.16 (floor) and form lane values before clipping
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      t[i] = {{2{s2_prod[i][63]}}, s2_prod[i][63:16]};
    end
    for (int i = 0; i < 3; i++) begin
      ea[i] = {{18{s2_a[i][31]}}, s2_a[i]};
      eb[i] = {{18{s2_b[i][31]}}, s2_b[i]};
      w_next[i] = '0;
    end
    sumsq_next = $unsigned(s2_prod[0]) + $unsigned(s2_prod[1]) + $unsigned(s2_prod[2]);
    unique case (s2_op)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) w_next[i] = ea[i] + eb[i];
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) w_next[i] = ea[i] - eb[i];
      end
      OP_DOT: begin
        w_next[0] = t[0] + t[1] + t[2];
      end
      OP_CROSS: begin
        w_next[0] = t[0] - t[1];
        w_next[1] = t[2] - t[3];
        w_next[2] = t[4] - t[5];
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) w_next[i] = t[i];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) cl[i] = clip32(s3_w[i]);
  end

  // Valid bits: advance with the pipeline, clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_v;
    end
  end

  // Payload: advance stage by stage
  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= in_item.opcode;
      for (int i = 0; i < 3; i++) begin
        s1_a[i] <= fa[i];
        s1_b[i] <= fb[i];
      end
      for (int i = 0; i < 6; i++) begin
        s1_ma[i]   <= ma_next[i];
        s1_mb[i]   <= mb_next[i];
        s2_prod[i] <= s1_ma[i] * s1_mb[i];
      end
      s2_op <= s1_op;
      s2_a  <= s1_a;
      s2_b  <= s1_b;
      s3_op    <= s2_op;
      s3_a     <= s2_a;
      s3_w     <= w_next;
      s3_sumsq <= sumsq_next;
      out_side.opcode           <= s3_op;
      out_side.prelim.result_x  <= cl[0][31:0];
      out_side.prelim.result_y  <= cl[1][31:0];
      out_side.prelim.result_z  <= cl[2][31:0];
      out_side.prelim.saturated <= cl[0][32] | cl[1][32] | cl[2][32];
      out_side.vec_x            <= s3_a[0];
      out_side.vec_y            <= s3_a[1];
      out_side.vec_z            <= s3_a[2];
      out_sumsq                 <= s3_sumsq;
    end
  end

endmodule

`default_nettype wire

[rtl/core/v3alu_sqrt.sv]
// Pipelined floor square root of the 64-bit sum of squares, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_sqrt
  import v3alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  side_t       in_side,
  input  logic [63:0] in_sumsq,
  output logic        out_valid,
  output side_t       out_side,
  output logic [31:0] out_root
);

  localparam int unsigned LAST = SQRT_STEPS - 1;

  logic        st_v    [SQRT_STEPS];
  side_t       st_side [SQRT_STEPS];
  logic [63:0] st_sq   [SQRT_STEPS];
  logic [32:0] st_rem  [SQRT_STEPS];
  logic [31:0] st_root [SQRT_STEPS];

  logic [63:0] psq       [SQRT_STEPS];
  logic [32:0] prem      [SQRT_STEPS];
  logic [31:0] proot     [SQRT_STEPS];
  logic [34:0] rem_sh    [SQRT_STEPS];
  logic [34:0] trial     [SQRT_STEPS];
  logic [32:0] rem_next  [SQRT_STEPS];
  logic [31:0] root_next [SQRT_STEPS];

  // One restoring step per stage: bring down two radicand bits, try a root bit
  always_comb begin
    psq[0]   = in_sumsq;
    prem[0]  = '0;
    proot[0] = '0;
    for (int k = 1; k < SQRT_STEPS; k++) begin
      psq[k]   = st_sq[k-1];
      prem[k]  = st_rem[k-1];
      proot[k] = st_root[k-1];
    end
    for (int k = 0; k < SQRT_STEPS; k++) begin
      rem_sh[k] = {prem[k], psq[k][63:62]};
      trial[k]  = {1'b0, proot[k], 2'b01};
      if (rem_sh[k] >= trial[k]) begin
        rem_next[k]  = 33'(rem_sh[k] - trial[k]);
        root_next[k] = {proot[k][30:0], 1'b1};
      end else begin
        rem_next[k]  = rem_sh[k][32:0];
        root_next[k] = {proot[k][30:0], 1'b0};
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_STEPS; k++) st_v[k] <= 1'b0;
    end else if (en) begin
      st_v[0] <= in_valid;
      for (int k = 1; k < SQRT_STEPS; k++) st_v[k] <= st_v[k-1];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      st_side[0] <= in_side;
      for (int k = 1; k < SQRT_STEPS; k++) st_side[k] <= st_side[k-1];
      for (int k = 0; k < SQRT_STEPS; k++) begin
        st_sq[k]   <= {psq[k][61:0], 2'b00};
        st_rem[k]  <= rem_next[k];
        st_root[k] <= root_next[k];
      end
    end
  end

  assign out_valid = st_v[LAST];
  assign out_side  = st_side[LAST];
  assign out_root  = st_root[LAST];

endmodule

`default_nettype wire

[rtl/core/v3alu_div.sv]
// Pipelined normalise divider (three lanes) and final result select.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_div
  import v3alu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  side_t       in_side,
  input  logic [31:0] in_root,
  output logic        out_valid,
  output result_t     out_result
);

  localparam int unsigned LAST  = DIV_STEPS - 1;
  localparam int unsigned QBITS = DIV_STEPS;

  logic             st_v    [DIV_STEPS];
  side_t            st_side [DIV_STEPS];
  logic [31:0]      st_m    [DIV_STEPS];
  logic [2:0][31:0] st_rem  [DIV_STEPS];
  logic [2:0][QBITS-1:0] st_q [DIV_STEPS];

  logic [31:0]      mag     [3];
  logic [31:0]      prem    [DIV_STEPS][3];
  logic [QBITS-1:0] pq      [DIV_STEPS][3];
  logic [31:0]      pm      [DIV_STEPS];
  logic             dbit    [DIV_STEPS][3];
  logic [32:0]      rsh     [DIV_STEPS][3];
  logic [31:0]      rem_next [DIV_STEPS][3];
  logic [QBITS-1:0] q_next  [DIV_STEPS][3];

  logic [31:0]      root;
  logic [31:0]      qx [3];
  logic [31:0]      nv [3];
  logic             neg [3];

  // Numerator is |c| << 16; its top bits already sit below the divisor
  always_comb begin
    mag[0] = in_side.vec_x[31] ? 32'(~in_side.vec_x + 32'd1) : in_side.vec_x;
    mag[1] = in_side.vec_y[31] ? 32'(~in_side.vec_y + 32'd1) : in_side.vec_y;
    mag[2] = in_side.vec_z[31] ? 32'(~in_side.vec_z + 32'd1) : in_side.vec_z;
    pm[0] = in_root;
    for (int i = 0; i < 3; i++) begin
      prem[0][i] = {1'b0, mag[i][31:1]};
      pq[0][i]   = '0;
      dbit[0][i] = mag[i][0];
    end
    for (int k = 1; k < DIV_STEPS; k++) begin
      pm[k] = st_m[k-1];
      for (int i = 0; i < 3; i++) begin
        prem[k][i] = st_rem[k-1][i];
        pq[k][i]   = st_q[k-1][i];
        dbit[k][i] = 1'b0;
      end
    end
    // One restoring quotient bit per stage and lane
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < 3; i++) begin
        rsh[k][i] = {prem[k][i], dbit[k][i]};
        if (rsh[k][i] >= {1'b0, pm[k]}) begin
          rem_next[k][i] = 32'(rsh[k][i] - {1'b0, pm[k]});
          q_next[k][i]   = {pq[k][i][QBITS-2:0], 1'b1};
        end else begin
          rem_next[k][i] = rsh[k][i][31:0];
          q_next[k][i]   = {pq[k][i][QBITS-2:0], 1'b0};
        end
      end
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) st_v[k] <= 1'b0;
    end else if (en) begin
      st_v[0] <= in_valid;
      for (int k = 1; k < DIV_STEPS; k++) st_v[k] <= st_v[k-1];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (en) begin
      st_side[0] <= in_side;
      for (int k = 1; k < DIV_STEPS; k++) st_side[k] <= st_side[k-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        st_m[k] <= pm[k];
        for (int i = 0; i < 3; i++) begin
          st_rem[k][i] <= rem_next[k][i];
          st_q[k][i]   <= q_next[k][i];
        end
      end
    end
  end

  // Select the result: magnitude and normalise replace the front's value
  always_comb begin
    root   = st_m[LAST];
    neg[0] = st_side[LAST].vec_x[31];
    neg[1] = st_side[LAST].vec_y[31];
    neg[2] = st_side[LAST].vec_z[31];
    for (int i = 0; i < 3; i++) begin
      qx[i] = {{(32-QBITS){1'b0}}, st_q[LAST][i]};
      nv[i] = (root == '0) ? '0 : (neg[i] ? 32'(~qx[i] + 32'd1) : qx[i]);
    end
    out_result = st_side[LAST].prelim;
    unique case (st_side[LAST].opcode)
      OP_MAG: begin
        out_result.result_x  = root[31] ? 32'h7FFF_FFFF : root;
        out_result.result_y  = '0;
        out_result.result_z  = '0;
        out_result.saturated = root[31];
      end
      OP_NORM: begin
        out_result.result_x  = nv[0];
        out_result.result_y  = nv[1];
        out_result.result_z  = nv[2];
        out_result.saturated = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = st_v[LAST];

endmodule

`default_nettype wire

[rtl/core/v3alu_out.sv]
// Output register with a skid stage; holds the pipeline while the skid is full.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_out
  import v3alu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    tail_valid,
  input  result_t tail_result,
  output logic    en,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic    sk_valid;
  result_t sk;

  assign en = !sk_valid;

  // Control: fill the skid on a stalled output, drain it when free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sk_valid     <= 1'b0;
    end else if (result_valid && result_stall) begin
      if (!sk_valid && tail_valid) begin
        sk_valid <= 1'b1;
      end
    end else if (sk_valid) begin
      result_valid <= 1'b1;
      sk_valid     <= 1'b0;
    end else begin
      result_valid <= tail_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (result_valid && result_stall) begin
      if (!sk_valid) begin
        sk <= tail_result;
      end
    end else if (sk_valid) begin
      result <= sk;
    end else begin
      result <= tail_result;
    end
  end

endmodule

`default_nettype wire

[rtl/core/vector3_alu_core.sv]
// Top level of the pipelined Q16.16 3D vector unit.
//
// Input channel: item_valid / item_stall / item (item_t). An item is taken at a
// rising edge with item_valid high and item_stall low. Output channel:
// result_valid / result_stall / result (result_t), same rule.
// Each item gives one result, in order. Opcodes: add, subtract, dot, cross,
// magnitude, normalise, scale; scalar results sit in result_x.
// The pipeline has four front stages (operand select, multiply, combine,
// saturate), 32 square root stages at one root bit each, 17 divider stages at
// one quotient bit each, and the output register.
// Throughput is one item per cycle while item_stall is low; the 32-bit
// multipliers and the one-bit root and quotient steps set the stage depth.
// Reset (rst, synchronous) clears every valid bit; no item is held after it.
// When the receiver stalls, the waiting result holds and one more item lands
// in a skid stage; only then does item_stall rise and the whole pipeline hold.
`timescale 1ns / 1ps
`default_nettype none

module vector3_alu_core
  import v3alu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic        en;
  logic        fr_valid;
  side_t       fr_side;
  logic [63:0] fr_sumsq;
  logic        sq_valid;
  side_t       sq_side;
  logic [31:0] sq_root;
  logic        dv_valid;
  result_t     dv_result;

  assign item_stall = !en;

  v3alu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (item_valid),
    .in_item   (item),
    .out_valid (fr_valid),
    .out_side  (fr_side),
    .out_sumsq (fr_sumsq)
  );

  v3alu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_side   (fr_side),
    .in_sumsq  (fr_sumsq),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  v3alu_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (sq_valid),
    .in_side    (sq_side),
    .in_root    (sq_root),
    .out_valid  (dv_valid),
    .out_result (dv_result)
  );

  v3alu_out u_out (
    .clk          (clk),
    .rst          (rst),
    .tail_valid   (dv_valid),
    .tail_result  (dv_result),
    .en           (en),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

[rtl/core/v3alu_checker.sv]
// Port-level checks of the vector unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module v3alu_checker
  import v3alu_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Input stalls only behind a waiting result that was stalled last cycle
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && $past(result_valid && result_stall))
    else $error("input stalled without a stalled result");

  // A saturated result carries a clipped component
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.saturated |->
      result.result_x == 32'sh7FFF_FFFF || result.result_x == 32'sh8000_0000 ||
      result.result_y == 32'sh7FFF_FFFF || result.result_y == 32'sh8000_0000 ||
      result.result_z == 32'sh7FFF_FFFF || result.result_z == 32'sh8000_0000)
    else $error("saturated flag without a clipped component");

endmodule

bind vector3_alu_core v3alu_checker u_checker (.*);

`default_nettype wire
